// File: rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// shared types and constants of the multi-button debouncer
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int MAX_BUTTONS = 8;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_COUNTER_MAX       = 3'd0;
    localparam logic [2:0] REG_PRESS_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_RELEASE_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_ACTIVE_LOW        = 3'd3;
    localparam logic [2:0] REG_EVENT_ON_RELEASE  = 3'd4;

    // input action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [CNT_W-1:0] RST_COUNTER_MAX       = 7'd10;
    localparam logic [CNT_W-1:0] RST_PRESS_THRESHOLD   = 7'd8;
    localparam logic [CNT_W-1:0] RST_RELEASE_THRESHOLD = 7'd2;

    typedef struct packed {
        logic                   action;
        logic [MAX_BUTTONS-1:0] pin_levels;
        logic [IDX_W-1:0]       clear_index;
    } mbd_in_t;

    typedef struct packed {
        logic [MAX_BUTTONS-1:0] pending_events;
        logic [MAX_BUTTONS-1:0] debounced_state;
    } mbd_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] counter_max;
        logic [CNT_W-1:0] press_threshold;
        logic [CNT_W-1:0] release_threshold;
        logic             active_low;
        logic             event_on_release;
    } mbd_cfg_t;

    typedef struct packed {
        logic en;
        logic tick;
        logic clear_hit;
        logic pin;
    } mbd_btn_ctrl_t;

    typedef struct packed {
        logic pressed;
        logic pending;
    } mbd_btn_status_t;

endpackage

// File: rtl/mbd_button.sv
// ----------------------------------------------------------------------------
// mbd_button
// one button: integrating counter, debounced state with hysteresis and
// pending event bit
// ----------------------------------------------------------------------------
module mbd_button (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mbd_pkg::mbd_cfg_t        cfg,
    input  mbd_pkg::mbd_btn_ctrl_t   ctrl,
    output mbd_pkg::mbd_btn_status_t status_next
);

    logic [mbd_pkg::CNT_W-1:0] cnt_reg;
    logic [mbd_pkg::CNT_W-1:0] cnt_next;
    logic                      pressed_reg;
    logic                      pressed_next;
    logic                      pending_reg;
    logic                      pending_next;

    logic                      active;
    logic [mbd_pkg::CNT_W:0]   step;
    logic [mbd_pkg::CNT_W-1:0] cnt_upd;

    always_comb
    begin
        active = ctrl.pin ^ cfg.active_low;
        if (active)
        begin
            step = {1'b0, cnt_reg} + {{mbd_pkg::CNT_W{1'b0}}, 1'b1};
        end
        else if (cnt_reg != '0)
        begin
            step = {1'b0, cnt_reg} - {{mbd_pkg::CNT_W{1'b0}}, 1'b1};
        end
        else
        begin
            step = '0;
        end
        if (step > {1'b0, cfg.counter_max})
        begin
            cnt_upd = cfg.counter_max;
        end
        else
        begin
            cnt_upd = step[mbd_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        pressed_next = pressed_reg;
        pending_next = pending_reg;
        if (ctrl.tick)
        begin
            cnt_next = cnt_upd;
            if (!pressed_reg)
            begin
                if (cnt_upd >= cfg.press_threshold)
                begin
                    pressed_next = 1'b1;
                    if (!cfg.event_on_release)
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            else if (cnt_upd <= cfg.release_threshold)
            begin
                pressed_next = 1'b0;
                if (cfg.event_on_release)
                begin
                    pending_next = 1'b1;
                end
            end
        end
        else if (ctrl.clear_hit)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pressed_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            cnt_reg     <= cnt_next;
            pressed_reg <= pressed_next;
            pending_reg <= pending_next;
        end
    end

    assign status_next.pressed = pressed_next;
    assign status_next.pending = pending_next;

endmodule

// File: rtl/mbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbd_cfg_regs
// apb register file holding the debounce configuration
// ----------------------------------------------------------------------------
module mbd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
    output logic [mbd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mbd_pkg::mbd_cfg_t           cfg
);

    mbd_pkg::mbd_cfg_t cfg_reg;
    mbd_pkg::mbd_cfg_t cfg_next;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mbd_pkg::REG_COUNTER_MAX:       cfg_next.counter_max = pwdata[6:0];
                mbd_pkg::REG_PRESS_THRESHOLD:   cfg_next.press_threshold = pwdata[6:0];
                mbd_pkg::REG_RELEASE_THRESHOLD: cfg_next.release_threshold = pwdata[6:0];
                mbd_pkg::REG_ACTIVE_LOW:        cfg_next.active_low = pwdata[0];
                mbd_pkg::REG_EVENT_ON_RELEASE:  cfg_next.event_on_release = pwdata[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mbd_pkg::REG_COUNTER_MAX:       prdata = {25'd0, cfg_reg.counter_max};
            mbd_pkg::REG_PRESS_THRESHOLD:   prdata = {25'd0, cfg_reg.press_threshold};
            mbd_pkg::REG_RELEASE_THRESHOLD: prdata = {25'd0, cfg_reg.release_threshold};
            mbd_pkg::REG_ACTIVE_LOW:        prdata = {31'd0, cfg_reg.active_low};
            mbd_pkg::REG_EVENT_ON_RELEASE:  prdata = {31'd0, cfg_reg.event_on_release};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counter_max       <= mbd_pkg::RST_COUNTER_MAX;
            cfg_reg.press_threshold   <= mbd_pkg::RST_PRESS_THRESHOLD;
            cfg_reg.release_threshold <= mbd_pkg::RST_RELEASE_THRESHOLD;
            cfg_reg.active_low        <= 1'b0;
            cfg_reg.event_on_release  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/multi_button_debouncer_core.sv
// ----------------------------------------------------------------------------
// multi_button_debouncer_core
// integrating-counter debouncer with hysteresis for up to eight buttons
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+----------------------------
//   in       | input     | in_valid/in_stall | mbd_in_t  (action, pins)
//   out      | output    | out_valid/out_stall| mbd_out_t (events, state)
//   cfg      | input     | apb psel/penable  | 32-bit registers at 4*i
//
// one item per cycle sustained while out_stall is low; an item is held in the
// input register and its result is registered in the output register
// all buttons update in parallel in a single pass between the two registers
// reset clears counters, debounced state, pending events and valids
// a stalled result holds the output register; the input register then holds
// its item and in_stall rises until the result is taken
// ----------------------------------------------------------------------------
module multi_button_debouncer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mbd_pkg::mbd_in_t            in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mbd_pkg::mbd_out_t           out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
    output logic [mbd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    mbd_pkg::mbd_cfg_t cfg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    mbd_pkg::mbd_in_t  s1_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    mbd_pkg::mbd_out_t out_item_reg;
    mbd_pkg::mbd_out_t out_item_next;

    logic              s1_fire;
    logic              in_take;

    mbd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    genvar i;
    generate
        for (i = 0; i < mbd_pkg::MAX_BUTTONS; i++)
        begin : g_btn
            if (i < mbd_pkg::NUM_BUTTONS)
            begin : g_used
                mbd_pkg::mbd_btn_ctrl_t   ctrl;
                mbd_pkg::mbd_btn_status_t status;

                assign ctrl.en        = s1_fire;
                assign ctrl.tick      = s1_item_reg.action == mbd_pkg::ACT_TICK;
                assign ctrl.clear_hit = (s1_item_reg.action == mbd_pkg::ACT_CLEAR)
                                     && (s1_item_reg.clear_index == mbd_pkg::IDX_W'(i));
                assign ctrl.pin       = s1_item_reg.pin_levels[i];

                mbd_button u_button (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cfg         (cfg),
                    .ctrl        (ctrl),
                    .status_next (status)
                );

                assign out_item_next.pending_events[i]  = status.pending;
                assign out_item_next.debounced_state[i] = status.pressed;
            end
            else
            begin : g_unused
                assign out_item_next.pending_events[i]  = 1'b0;
                assign out_item_next.debounced_state[i] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a stall toward the source only while an item waits in the input register
    a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall without a held item");

    // a processed item always leaves a result behind
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed item produced no result");

    // an accepted item is held in the input register on the next cycle
    a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted item lost");

    // a result that is stalled keeps its value
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_item_reg) && out_valid_reg)
        else $error("stalled result changed");

    // buttons beyond the configured count never report anything
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_item_reg.pending_events >> mbd_pkg::NUM_BUTTONS) == '0)
                       && ((out_item_reg.debounced_state >> mbd_pkg::NUM_BUTTONS) == '0))
        else $error("unused button bit set");

endmodule
